FILE: sv/assert_macros.svh
// assertion macros used by the top-level receiver core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("label");
// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("label");
`endif

FILE: sv/ymrx_pkg.sv
// package: types and constants of the ymodem receiver
package ymrx_pkg;
  localparam logic [7:0] SOH = 8'h01;
  localparam logic [7:0] STX = 8'h02;
  localparam logic [7:0] EOT = 8'h04;
  localparam logic [7:0] ACK = 8'h06;
  localparam logic [7:0] NAK = 8'h15;
  localparam logic [7:0] CAN = 8'h18;
  localparam logic [7:0] REQ = 8'h43;
  localparam int MAXRES = 4;

  typedef enum logic [1:0] {K_BYTE = 2'd0, K_TICK = 2'd1, K_ANSWER = 2'd2, K_START = 2'd3}
    kind_t;
  typedef enum logic [2:0] {
    EV_REPLY = 3'd0, EV_DATA = 3'd1, EV_VERDICT = 3'd2, EV_OPEN_NAMED = 3'd3,
    EV_OPEN_ANON = 3'd4, EV_CLOSE = 3'd5, EV_CANCEL = 3'd6, EV_FINAL = 3'd7
  } event_t;
  typedef enum logic [2:0] {
    PH_STOPPED = 3'd0, PH_HEADER = 3'd1, PH_OPEN = 3'd2, PH_WAIT_NAMED = 3'd3,
    PH_WAIT_ANON = 3'd4
  } phase_t;
  typedef enum logic [1:0] {FM_IDLE = 2'd0, FM_SHORT = 2'd1, FM_LONG = 2'd2, FM_PURGE = 2'd3}
    fmode_t;
  typedef enum logic [1:0] {HP_NAME = 2'd0, HP_SEP = 2'd1, HP_DIGITS = 2'd2, HP_DONE = 2'd3}
    hparse_t;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_REMOTE = 2'd1;
  localparam logic [1:0] ST_OPEN = 2'd2;
  localparam logic [1:0] ST_SEQ = 2'd3;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  byte_value;
    logic [10:0] keep_count;
    logic [31:0] file_size;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       open_ok;
  } item_t;

  typedef struct packed {
    logic       eot;
    logic       purge;
    logic       first;
    logic       can;
    logic       xm;
    logic       empty;
  } flags_t;

  typedef struct packed {
    phase_t      phase;
    fmode_t      frame_mode;
    logic [10:0] frame_count;
    logic [7:0]  lead_byte;
    logic [7:0]  seq_byte;
    logic [7:0]  seq_inverse;
    logic [15:0] crc_acc;
    logic [7:0]  expected_seq;
    logic [7:0]  previous_seq;
    logic [31:0] remaining_size;
    hparse_t     header_parse;
    logic [31:0] size_accum;
    logic [7:0]  retry_left;
    flags_t      flags;
  } state_t;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
    end
    return x;
  endfunction
endpackage

FILE: sv/ymrx_if.sv
// valid/ready channel interfaces for items and results
interface ymrx_in_if (input logic clk);
  logic              valid;
  logic              ready;
  ymrx_pkg::item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ymrx_out_if (input logic clk);
  logic              valid;
  logic              ready;
  ymrx_pkg::res_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/ymrx_step.sv
// combinational next state and result list for one item
module ymrx_step (
  input  ymrx_pkg::state_t st_i,
  input  ymrx_pkg::item_t  item_i,
  input  logic             checksum_mode_i,
  input  logic             allow_long_i,
  input  logic [7:0]       retry_ticks_i,
  output ymrx_pkg::state_t st_o,
  output ymrx_pkg::res_t [ymrx_pkg::MAXRES-1:0] res_o,
  output logic [2:0]       res_n_o
);
  always_comb begin
    ymrx_pkg::state_t s;
    ymrx_pkg::res_t [ymrx_pkg::MAXRES-1:0] r;
    logic [2:0] n;
    logic [7:0] b;
    logic [10:0] idx, dlen, plen;
    logic [9:0] di;
    logic dig, ok, abandon_v;
    logic [31:0] k, tsize;
    s = st_i;
    r = '0;
    n = '0;
    b = item_i.rx_byte;
    idx = '0; dlen = '0; plen = '0; di = '0; dig = 1'b0; ok = 1'b0;
    abandon_v = 1'b0; k = '0; tsize = '0;

    // abandon / restart used by start and tick
    if (item_i.kind == ymrx_pkg::K_START ||
        (item_i.kind == ymrx_pkg::K_TICK &&
         (s.phase == ymrx_pkg::PH_HEADER || s.phase == ymrx_pkg::PH_OPEN))) begin
      abandon_v = (s.frame_mode == ymrx_pkg::FM_SHORT || s.frame_mode == ymrx_pkg::FM_LONG)
                  && s.frame_count > 11'd3;
      if (abandon_v) begin
        r[n].event_res = ymrx_pkg::EV_VERDICT; n = n + 3'd1;
      end
      s.frame_mode = ymrx_pkg::FM_IDLE;
      s.frame_count = '0;
    end

    case (item_i.kind)
      ymrx_pkg::K_START: begin
        r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::REQ; n = n + 3'd1;
        s.flags = '0; s.phase = ymrx_pkg::PH_HEADER; s.expected_seq = '0;
        s.retry_left = retry_ticks_i;
      end
      ymrx_pkg::K_TICK: begin
        if (s.phase == ymrx_pkg::PH_HEADER || s.phase == ymrx_pkg::PH_OPEN) begin
          if (s.flags.purge) begin
            r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::REQ;
            n = n + 3'd1;
            s.flags.purge = 1'b0;
          end else if (s.phase == ymrx_pkg::PH_HEADER) begin
            if (s.retry_left != 8'd0) s.retry_left = s.retry_left - 8'd1;
            else begin
              r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::REQ;
              n = n + 3'd1;
              s.flags = '0; s.phase = ymrx_pkg::PH_HEADER; s.expected_seq = '0;
              s.retry_left = retry_ticks_i;
            end
          end else begin
            s.flags.eot = 1'b0; s.flags.can = 1'b0;
            r[n].event_res = ymrx_pkg::EV_REPLY;
            r[n].byte_value = s.flags.first ? ymrx_pkg::REQ : ymrx_pkg::NAK;
            n = n + 3'd1;
          end
        end
      end
      ymrx_pkg::K_ANSWER: begin
        if (s.phase == ymrx_pkg::PH_WAIT_NAMED) begin
          if (item_i.open_ok) begin
            r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::ACK;
            n = n + 3'd1;
            s.previous_seq = 8'd0; s.expected_seq = 8'd1; s.phase = ymrx_pkg::PH_OPEN;
            s.flags.first = 1'b1;
          end else begin
            r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::CAN;
            n = n + 3'd1;
            r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::CAN;
            n = n + 3'd1;
            r[n].event_res = ymrx_pkg::EV_FINAL; r[n].status = ymrx_pkg::ST_OPEN;
            n = n + 3'd1;
            s.phase = ymrx_pkg::PH_STOPPED; s.frame_mode = ymrx_pkg::FM_IDLE;
            s.frame_count = '0;
          end
        end else if (s.phase == ymrx_pkg::PH_WAIT_ANON) begin
          if (item_i.open_ok) begin
            if (s.remaining_size < 32'd128) begin
              k = s.remaining_size; s.remaining_size = '0;
            end else begin
              k = 32'd128; s.remaining_size = s.remaining_size - 32'd128;
            end
            r[n].event_res = ymrx_pkg::EV_VERDICT; r[n].keep_count = k[10:0];
            n = n + 3'd1;
            s.previous_seq = 8'd1; s.expected_seq = 8'd2; s.phase = ymrx_pkg::PH_OPEN;
            s.flags.xm = 1'b1; s.flags.first = 1'b0;
            r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::ACK;
            n = n + 3'd1;
          end else begin
            r[n].event_res = ymrx_pkg::EV_VERDICT; n = n + 3'd1;
            r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::CAN;
            n = n + 3'd1;
            r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::CAN;
            n = n + 3'd1;
            r[n].event_res = ymrx_pkg::EV_FINAL; r[n].status = ymrx_pkg::ST_OPEN;
            n = n + 3'd1;
            s.phase = ymrx_pkg::PH_STOPPED; s.frame_mode = ymrx_pkg::FM_IDLE;
            s.frame_count = '0;
          end
        end
      end
      default: begin
        if ((s.phase == ymrx_pkg::PH_HEADER || s.phase == ymrx_pkg::PH_OPEN) &&
            s.frame_mode != ymrx_pkg::FM_PURGE) begin
          if (s.frame_mode == ymrx_pkg::FM_IDLE) begin
            if (b == ymrx_pkg::SOH || (b == ymrx_pkg::STX && allow_long_i)) begin
              s.frame_mode = (b == ymrx_pkg::SOH) ? ymrx_pkg::FM_SHORT : ymrx_pkg::FM_LONG;
              s.frame_count = 11'd1; s.lead_byte = b; s.crc_acc = '0;
              s.header_parse = ymrx_pkg::HP_NAME; s.size_accum = '0; s.flags.empty = 1'b0;
            end else if (b == ymrx_pkg::CAN || b == ymrx_pkg::EOT) begin
              // single control byte
              if (s.phase == ymrx_pkg::PH_HEADER) begin
                if (b == ymrx_pkg::CAN) begin
                  if (s.flags.can) begin
                    r[n].event_res = ymrx_pkg::EV_FINAL; r[n].status = ymrx_pkg::ST_REMOTE;
                    n = n + 3'd1;
                    s.phase = ymrx_pkg::PH_STOPPED;
                    s.frame_mode = ymrx_pkg::FM_IDLE; s.frame_count = '0;
                  end else begin
                    s.flags.can = 1'b1; s.retry_left = retry_ticks_i;
                  end
                end else begin
                  s.flags.can = 1'b0; s.retry_left = '0; s.flags.purge = 1'b1;
                  s.frame_mode = ymrx_pkg::FM_PURGE;
                end
              end else if (b == ymrx_pkg::CAN) begin
                s.flags.eot = 1'b0;
                if (s.flags.can) begin
                  r[n].event_res = ymrx_pkg::EV_CANCEL; n = n + 3'd1;
                  r[n].event_res = ymrx_pkg::EV_FINAL; r[n].status = ymrx_pkg::ST_REMOTE;
                  n = n + 3'd1;
                  s.phase = ymrx_pkg::PH_STOPPED;
                  s.frame_mode = ymrx_pkg::FM_IDLE; s.frame_count = '0;
                end else s.flags.can = 1'b1;
              end else if (s.flags.xm) begin
                s.flags.can = 1'b0;
                r[n].event_res = ymrx_pkg::EV_CLOSE; n = n + 3'd1;
                r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::ACK;
                n = n + 3'd1;
                r[n].event_res = ymrx_pkg::EV_FINAL; r[n].status = ymrx_pkg::ST_DONE;
                n = n + 3'd1;
                s.phase = ymrx_pkg::PH_STOPPED;
                s.frame_mode = ymrx_pkg::FM_IDLE; s.frame_count = '0;
              end else if (s.flags.eot) begin
                r[n].event_res = ymrx_pkg::EV_CLOSE; n = n + 3'd1;
                r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::ACK;
                n = n + 3'd1;
                r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::REQ;
                n = n + 3'd1;
                s.flags = '0; s.phase = ymrx_pkg::PH_HEADER; s.expected_seq = '0;
                s.retry_left = '0;
              end else begin
                s.flags.can = 1'b0; s.flags.eot = 1'b1;
                r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::NAK;
                n = n + 3'd1;
              end
            end
          end else begin
            // inside a packet
            dlen = (s.frame_mode == ymrx_pkg::FM_SHORT) ? 11'd128 : 11'd1024;
            plen = dlen + (checksum_mode_i ? 11'd4 : 11'd5);
            idx = s.frame_count;
            s.frame_count = s.frame_count + 11'd1;
            if (idx == 11'd1) s.seq_byte = b;
            else if (idx == 11'd2) s.seq_inverse = b;
            else if (idx >= 11'd3) begin
              di = 10'(idx - 11'd3);
              if ((idx - 11'd3) < dlen) begin
                r[n].event_res = ymrx_pkg::EV_DATA; r[n].byte_value = b; n = n + 3'd1;
                if (di < 10'd128) begin
                  dig = b >= 8'h30 && b <= 8'h39;
                  case (s.header_parse)
                    ymrx_pkg::HP_NAME: if (b == 8'd0) begin
                      if (di == 10'd0) s.flags.empty = 1'b1;
                      s.header_parse = ymrx_pkg::HP_SEP;
                    end
                    ymrx_pkg::HP_SEP: begin
                      if (b == 8'd0) s.size_accum = 32'hFFFF_FFFF;
                      else if (dig) s.size_accum = {28'd0, b[3:0]};
                      else s.size_accum = '0;
                      s.header_parse = dig ? ymrx_pkg::HP_DIGITS : ymrx_pkg::HP_DONE;
                    end
                    ymrx_pkg::HP_DIGITS: begin
                      if (dig) s.size_accum = (s.size_accum << 3) + (s.size_accum << 1)
                                              + {28'd0, b[3:0]};
                      else s.header_parse = ymrx_pkg::HP_DONE;
                    end
                    default: ;
                  endcase
                end
                if (checksum_mode_i) s.crc_acc = {8'd0, s.crc_acc[7:0] + b};
              end
              if (!checksum_mode_i) s.crc_acc = ymrx_pkg::crc_step(s.crc_acc, b);
            end
            if (s.frame_count >= plen) begin
              ok = s.seq_inverse == ~s.seq_byte;
              if (checksum_mode_i) ok = ok && (s.crc_acc[7:0] == b);
              else ok = ok && (s.crc_acc == 16'd0);
              s.frame_mode = ymrx_pkg::FM_IDLE;
              s.frame_count = '0;
              if (s.phase == ymrx_pkg::PH_HEADER) begin
                if (ok && s.lead_byte == ymrx_pkg::SOH && s.seq_byte == 8'd0) begin
                  s.flags.can = 1'b0; s.retry_left = '0;
                  if (s.flags.empty) begin
                    r[n].event_res = ymrx_pkg::EV_VERDICT; n = n + 3'd1;
                    r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::ACK;
                    n = n + 3'd1;
                    r[n].event_res = ymrx_pkg::EV_FINAL; r[n].status = ymrx_pkg::ST_DONE;
                    n = n + 3'd1;
                    s.phase = ymrx_pkg::PH_STOPPED;
                  end else begin
                    s.remaining_size = (s.header_parse == ymrx_pkg::HP_DIGITS ||
                                        s.header_parse == ymrx_pkg::HP_DONE)
                                       ? s.size_accum : 32'hFFFF_FFFF;
                    r[n].event_res = ymrx_pkg::EV_OPEN_NAMED;
                    r[n].file_size = s.remaining_size; n = n + 3'd1;
                    s.phase = ymrx_pkg::PH_WAIT_NAMED;
                  end
                end else if (ok && s.lead_byte == ymrx_pkg::SOH && s.seq_byte == 8'd1) begin
                  s.flags.can = 1'b0; s.retry_left = '0;
                  s.remaining_size = 32'hFFFF_FFFF;
                  r[n].event_res = ymrx_pkg::EV_OPEN_ANON; n = n + 3'd1;
                  s.phase = ymrx_pkg::PH_WAIT_ANON;
                end else begin
                  r[n].event_res = ymrx_pkg::EV_VERDICT; n = n + 3'd1;
                  s.flags.can = 1'b0; s.retry_left = '0; s.flags.purge = 1'b1;
                  s.frame_mode = ymrx_pkg::FM_PURGE;
                end
              end else if (!ok) begin
                r[n].event_res = ymrx_pkg::EV_VERDICT; n = n + 3'd1;
                s.flags.can = 1'b0; s.flags.eot = 1'b0; s.flags.purge = 1'b1;
                s.frame_mode = ymrx_pkg::FM_PURGE;
              end else begin
                s.flags.eot = 1'b0; s.flags.can = 1'b0;
                if (s.seq_byte == s.previous_seq) begin
                  r[n].event_res = ymrx_pkg::EV_VERDICT; n = n + 3'd1;
                  r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::ACK;
                  n = n + 3'd1;
                end else if (s.seq_byte != s.expected_seq) begin
                  r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::CAN;
                  n = n + 3'd1;
                  r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::CAN;
                  n = n + 3'd1;
                  r[n].event_res = ymrx_pkg::EV_CANCEL; n = n + 3'd1;
                  r[n].event_res = ymrx_pkg::EV_FINAL; r[n].status = ymrx_pkg::ST_SEQ;
                  n = n + 3'd1;
                  s.phase = ymrx_pkg::PH_STOPPED;
                end else begin
                  tsize = (s.lead_byte == ymrx_pkg::SOH) ? 32'd128 : 32'd1024;
                  if (tsize > s.remaining_size) begin
                    k = s.remaining_size; s.remaining_size = '0;
                  end else begin
                    k = tsize; s.remaining_size = s.remaining_size - tsize;
                  end
                  r[n].event_res = ymrx_pkg::EV_VERDICT; r[n].keep_count = k[10:0];
                  n = n + 3'd1;
                  s.flags.first = 1'b0;
                  s.previous_seq = s.expected_seq;
                  s.expected_seq = s.expected_seq + 8'd1;
                  r[n].event_res = ymrx_pkg::EV_REPLY; r[n].byte_value = ymrx_pkg::ACK;
                  n = n + 3'd1;
                end
              end
            end
          end
        end
      end
    endcase
    if (n != 3'd0) r[n - 3'd1].last = 1'b1;
    st_o = s;
    res_o = r;
    res_n_o = n;
  end
endmodule

FILE: sv/ymodem_receiver_byte_step_core.sv
// top level: ymodem / xmodem receiver, one item per cycle while output drains
// ymodem / xmodem receiver. each input item (a received byte, a silence tick,
// an open answer or a start command) is registered, then one pass of
// combinational logic computes the new protocol state and up to four result
// items, which are loaded into a small result buffer and drained one per
// cycle while the output is ready. an item with at most one result is
// taken every cycle while the output is ready; one with more holds back
// the next item until its results drain, so the sustained rate is one item
// per cycle for byte streams, set by the result drain when replies pile up.
`include "assert_macros.svh"
module ymodem_receiver_byte_step_core (
  input  logic clk,
  input  logic rst_n,
  ymrx_in_if.sink    in_ch,
  ymrx_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  localparam logic [1:0] CFG_CHECKSUM = 2'd0;
  localparam logic [1:0] CFG_LONG = 2'd1;
  localparam logic [1:0] CFG_RETRY = 2'd2;

  logic checksum_mode_r, allow_long_r;
  logic [7:0] retry_ticks_r;
  ymrx_pkg::state_t st_r, st_nxt;
  ymrx_pkg::res_t [ymrx_pkg::MAXRES-1:0] res_nxt, buf_r;
  logic [2:0] res_n, cnt_r;   // results left in buffer
  logic [1:0] rd_r;           // read pointer
  logic item_v_r;
  ymrx_pkg::item_t item_r;
  logic take_in, pop, step_ok;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checksum_mode_r <= 1'b0;
      allow_long_r <= 1'b1;
      retry_ticks_r <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHECKSUM: checksum_mode_r <= cfg_wdata[0];
        CFG_LONG:     allow_long_r <= cfg_wdata[0];
        CFG_RETRY:    retry_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ymrx_step u_step (
    .st_i(st_r), .item_i(item_r), .checksum_mode_i(checksum_mode_r),
    .allow_long_i(allow_long_r), .retry_ticks_i(retry_ticks_r),
    .st_o(st_nxt), .res_o(res_nxt), .res_n_o(res_n)
  );

  assign pop = out_ch.valid && out_ch.ready;
  // registered item is processed once the buffer will be empty
  assign step_ok = item_v_r && (cnt_r == 3'd0 || (cnt_r == 3'd1 && pop));
  assign in_ch.ready = !item_v_r || step_ok;
  assign take_in = in_ch.valid && in_ch.ready;
  assign out_ch.valid = cnt_r != 3'd0;
  assign out_ch.data = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      cnt_r <= '0;
      rd_r <= '0;
      st_r <= '{phase: ymrx_pkg::PH_STOPPED, frame_mode: ymrx_pkg::FM_IDLE,
                header_parse: ymrx_pkg::HP_NAME, remaining_size: 32'hFFFF_FFFF,
                retry_left: 8'd10, default: '0};
    end else begin
      if (take_in) item_v_r <= 1'b1;
      else if (step_ok) item_v_r <= 1'b0;
      if (step_ok) begin
        st_r <= st_nxt;
        cnt_r <= res_n;
        rd_r <= '0;
      end else if (pop) begin
        cnt_r <= cnt_r - 3'd1;
        rd_r <= rd_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) item_r <= in_ch.data;
    if (step_ok) buf_r <= res_nxt;
  end

  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= 3'd4)
  `ASSERT_NEXT(a_last_drains, clk, rst_n, pop && out_ch.data.last && !step_ok, cnt_r == 3'd0)
  `ASSERT_ALWAYS(a_stopped_idle, clk, rst_n,
                 st_r.phase != ymrx_pkg::PH_STOPPED || st_r.frame_mode == ymrx_pkg::FM_IDLE)
endmodule
